// ===== hw/rtl/mrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU response checker package
// Transaction types, item kind codes, verdict codes, function codes and CRC
// constants shared by the checker modules.
// ----------------------------------------------------------------------------
package mrc_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_ARM  = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// Result item kinds.
	localparam logic [1:0] OUT_DATA   = 2'd0;
	localparam logic [1:0] OUT_REG    = 2'd1;
	localparam logic [1:0] OUT_STATUS = 2'd2;

	// Frame verdicts.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT = 3'd1;
	localparam logic [2:0] ST_CRC_ERROR = 3'd2;
	localparam logic [2:0] ST_BAD_RESP  = 3'd3;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd4;

	// Function codes that change the checking rules.
	localparam logic [7:0] FN_READ_COILS     = 8'h01;
	localparam logic [7:0] FN_READ_DISCRETE  = 8'h02;
	localparam logic [7:0] FN_READ_HOLDING   = 8'h03;
	localparam logic [7:0] FN_READ_INPUT_REG = 8'h04;
	localparam logic [7:0] FN_WRITE_SINGLE   = 8'h06;
	localparam logic [7:0] FN_WRITE_MULTIPLE = 8'h10;

	// CRC-16/Modbus, reflected.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Shortest valid frame and shortest write echo, in bytes.
	localparam int unsigned MIN_FRAME = 5;
	localparam int unsigned MIN_ECHO  = 8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  expect_slave;
		logic [7:0]  expect_function;
		logic [10:0] expect_quantity;
		logic [7:0]  rx_byte;
	} mrc_in_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [15:0] out_value;
		logic [7:0]  out_index;
		logic [2:0]  status;
		logic        frame_done;
	} mrc_out_t;

	// Result of processing one item: whether it yields a result, and the result.
	typedef struct packed {
		logic     produced;
		mrc_out_t item;
	} mrc_res_t;

endpackage

// ===== hw/rtl/mrc_crc16_step.sv =====
// ----------------------------------------------------------------------------
// CRC-16 byte step
// Folds one byte into a reflected CRC-16, eight shift steps, combinationally.
// ----------------------------------------------------------------------------
module mrc_crc16_step (
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);

	always_comb begin
		logic [15:0] acc;
		acc = crc ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ mrc_pkg::CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
		end
		crc_next = acc;
	end

endmodule

// ===== hw/rtl/mrc_frame_engine.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU frame engine
// Holds the armed expectations and the frame capture state, and works out
// the result of one item in a single pass.
// ----------------------------------------------------------------------------
module mrc_frame_engine #(
	parameter int MAX_FRAME = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  mrc_pkg::mrc_in_t item,
	output mrc_pkg::mrc_res_t res
);

	localparam int LW = $clog2(MAX_FRAME + 1);

	logic [7:0]       want_slave_q, want_slave_d;
	logic [7:0]       want_function_q, want_function_d;
	logic [10:0]      want_quantity_q, want_quantity_d;
	logic [LW-1:0]    len_q, len_d;
	logic [15:0]      crc_q, crc_d, crc_fold;
	logic [2:0][7:0]  hist_q, hist_d;
	logic [7:0]       got_slave_q, got_slave_d;
	logic [7:0]       got_function_q, got_function_d;
	logic [7:0]       got_count_q, got_count_d;
	logic [9:0]       len10;
	logic [7:0]       off;
	logic [2:0]       verdict;
	logic             header_ok;

	mrc_crc16_step u_crc (
		.crc      (crc_q),
		.data     (hist_q[1]),
		.crc_next (crc_fold)
	);

	assign len10     = 10'(len_q);
	assign off       = 8'(len_q) - 8'(mrc_pkg::MIN_FRAME);
	assign header_ok = (got_slave_q == want_slave_q) && (got_function_q == want_function_q);

	// Verdict on the captured frame, in order of precedence.
	always_comb begin
		verdict = mrc_pkg::ST_OK;
		if (len10 < 10'(mrc_pkg::MIN_FRAME)) begin
			verdict = mrc_pkg::ST_TOO_SHORT;
		end else if ({hist_q[0], hist_q[1]} != crc_q) begin
			verdict = mrc_pkg::ST_CRC_ERROR;
		end else begin
			case (want_function_q)
				mrc_pkg::FN_READ_COILS, mrc_pkg::FN_READ_DISCRETE: begin
					if (!header_ok) begin
						verdict = mrc_pkg::ST_BAD_RESP;
					end else if (10'(got_count_q) + 10'(mrc_pkg::MIN_FRAME) != len10) begin
						verdict = mrc_pkg::ST_BAD_SIZE;
					end
				end
				mrc_pkg::FN_READ_HOLDING, mrc_pkg::FN_READ_INPUT_REG: begin
					if (!header_ok) begin
						verdict = mrc_pkg::ST_BAD_RESP;
					end else if (10'(got_count_q) + 10'(mrc_pkg::MIN_FRAME) != len10) begin
						verdict = mrc_pkg::ST_BAD_SIZE;
					end else if ({4'h0, got_count_q} != {want_quantity_q, 1'b0}) begin
						verdict = mrc_pkg::ST_BAD_SIZE;
					end
				end
				mrc_pkg::FN_WRITE_SINGLE, mrc_pkg::FN_WRITE_MULTIPLE: begin
					if (len10 < 10'(mrc_pkg::MIN_ECHO) || !header_ok) begin
						verdict = mrc_pkg::ST_BAD_RESP;
					end
				end
				default: begin
					if (!header_ok) begin
						verdict = mrc_pkg::ST_BAD_RESP;
					end
				end
			endcase
		end
	end

	always_comb begin
		logic clear;
		clear           = 1'b0;
		want_slave_d    = want_slave_q;
		want_function_d = want_function_q;
		want_quantity_d = want_quantity_q;
		len_d           = len_q;
		crc_d           = crc_q;
		hist_d          = hist_q;
		got_slave_d     = got_slave_q;
		got_function_d  = got_function_q;
		got_count_d     = got_count_q;
		res             = '0;
		case (item.kind)
			mrc_pkg::KIND_ARM: begin
				want_slave_d    = item.expect_slave;
				want_function_d = item.expect_function;
				want_quantity_d = item.expect_quantity;
				clear           = 1'b1;
			end
			mrc_pkg::KIND_BYTE: begin
				if (len_q < LW'(MAX_FRAME)) begin
					// The byte two places back is now known not to be CRC.
					if (len10 >= 10'd2) begin
						crc_d = crc_fold;
					end
					if (len10 >= 10'(mrc_pkg::MIN_FRAME)) begin
						if (want_function_q == mrc_pkg::FN_READ_COILS ||
						    want_function_q == mrc_pkg::FN_READ_DISCRETE) begin
							res.produced       = 1'b1;
							res.item.out_kind  = mrc_pkg::OUT_DATA;
							res.item.out_value = {8'h00, hist_q[1]};
							res.item.out_index = off;
						end else if ((want_function_q == mrc_pkg::FN_READ_HOLDING ||
						              want_function_q == mrc_pkg::FN_READ_INPUT_REG) &&
						             off[0]) begin
							res.produced       = 1'b1;
							res.item.out_kind  = mrc_pkg::OUT_REG;
							res.item.out_value = {hist_q[2], hist_q[1]};
							res.item.out_index = off >> 1;
						end
					end
					if (len10 == 10'd0) begin
						got_slave_d = item.rx_byte;
					end
					if (len10 == 10'd1) begin
						got_function_d = item.rx_byte;
					end
					if (len10 == 10'd2) begin
						got_count_d = item.rx_byte;
					end
					hist_d = {hist_q[1], hist_q[0], item.rx_byte};
					len_d  = len_q + LW'(1);
				end
			end
			mrc_pkg::KIND_END: begin
				res.produced         = 1'b1;
				res.item.out_kind    = mrc_pkg::OUT_STATUS;
				res.item.out_value   = {8'h00, got_count_q};
				res.item.status      = verdict;
				res.item.frame_done  = 1'b1;
				clear                = 1'b1;
			end
			default: begin
			end
		endcase
		if (clear) begin
			len_d          = '0;
			crc_d          = mrc_pkg::CRC_INIT;
			hist_d         = '0;
			got_slave_d    = '0;
			got_function_d = '0;
			got_count_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_slave_q    <= '0;
			want_function_q <= '0;
			want_quantity_q <= '0;
			len_q           <= '0;
			crc_q           <= mrc_pkg::CRC_INIT;
			hist_q          <= '0;
			got_slave_q     <= '0;
			got_function_q  <= '0;
			got_count_q     <= '0;
		end else if (advance) begin
			want_slave_q    <= want_slave_d;
			want_function_q <= want_function_d;
			want_quantity_q <= want_quantity_d;
			len_q           <= len_d;
			crc_q           <= crc_d;
			hist_q          <= hist_d;
			got_slave_q     <= got_slave_d;
			got_function_q  <= got_function_d;
			got_count_q     <= got_count_d;
		end
	end

endmodule

// ===== hw/rtl/modbus_rtu_response_checker.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU response checker
// Checks a streamed Modbus RTU response frame against the armed request and
// releases payload bytes or registers, then a verdict, as result transactions.
// ----------------------------------------------------------------------------
// The block takes one input transaction in every clock cycle while its input
// is not stalled, and turns it into at most one result transaction. An arm
// transaction loads the expected slave address, function code and quantity and
// restarts frame capture; byte transactions carry the response one byte at a
// time; an end transaction marks the inter-frame gap and yields one status
// result with frame_done set. A received byte is released as payload two bytes
// later, once it cannot be part of the CRC: single bytes for functions
// 0x01/0x02, big-endian register words for 0x03/0x04. An accepted transaction
// is held in the input register, and its result is loaded into the result
// register, which drives result_valid, once that register is free. Throughput
// is one transaction per cycle while the output side does not stall, set by the
// combinational CRC byte step and the one-pass checking logic between the two
// registers. Bytes beyond MAX_FRAME are dropped without a result. The input
// side stalls only while a result waits in the result register and the output
// side is stalling.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker #(
	parameter int MAX_FRAME = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_stall,
	input  mrc_pkg::mrc_in_t  frame_item,
	output logic              result_valid,
	input  logic              result_stall,
	output mrc_pkg::mrc_out_t result_item
);

	// Input register: the transaction under work this cycle.
	logic              vld_s1;
	mrc_pkg::mrc_in_t  item_s1;

	// Result register.
	logic              out_vld_q;
	mrc_pkg::mrc_out_t out_q;

	mrc_pkg::mrc_res_t res;
	logic              out_free;
	logic              advance;

	// The result register can take a new value when it is empty or being read.
	assign out_free    = !out_vld_q || !result_stall;
	assign advance     = vld_s1 && out_free;
	assign frame_stall = vld_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!frame_stall) begin
			vld_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!frame_stall && frame_valid) begin
			item_s1 <= frame_item;
		end
	end

	// All state updates and the result come from one pass over the held item.
	mrc_frame_engine #(
		.MAX_FRAME (MAX_FRAME)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= advance && res.produced;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.produced) begin
			out_q <= res.item;
		end
	end

	assign result_valid = out_vld_q;
	assign result_item  = out_q;

	// A held input transaction must not be overwritten while stalled.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		frame_stall |=> vld_s1 && $stable(item_s1))
		else $error("input register changed while stalled");

	// A new result only follows a transaction that was under work.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(vld_s1))
		else $error("result appeared without a source transaction");

	// Only status results close a frame.
	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_item.frame_done == (result_item.out_kind == mrc_pkg::OUT_STATUS)))
		else $error("frame_done disagrees with result kind");

	// Payload results carry no verdict.
	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_item.frame_done) |-> (result_item.status == mrc_pkg::ST_OK))
		else $error("payload result carries a verdict");

endmodule

// ===== tb/sv/modbus_rtu_response_checker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response checker testbench
// Streams arm, byte and end transactions into the checker and compares every
// payload and verdict transaction against an in-bench frame predictor.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_tb;

	import mrc_pkg::*;

	// The block parameter is kept at its default so that frames can reach
	// the full capture length and run past it.
	localparam int MAX_FRAME      = 256;
	localparam int ITEM_TARGET    = 1500;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MISMATCH_SHOWN = 10;
	localparam int QTY_MAX        = 2000;

	// The fourth kind code has no meaning; the block must swallow it.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     frame_valid;
	logic     frame_stall;
	mrc_in_t  frame_item;
	logic     result_valid;
	logic     result_stall;
	mrc_out_t result_item;

	// Idling switches for either side, and the request for a long hold-off.
	bit tx_idle_on   = 1'b1;
	bit rx_idle_on   = 1'b1;
	bit hold_off_req = 1'b0;

	// Frame predictor state: what the last arm asked for, and what has been
	// captured of the current response so far.
	logic [7:0]  armed_slave;
	logic [7:0]  armed_fn;
	logic [10:0] armed_qty;
	int          rx_len;
	logic [15:0] crc_acc;
	logic [7:0]  recent [3];
	logic [7:0]  hdr_slave;
	logic [7:0]  hdr_fn;
	logic [7:0]  hdr_count;

	// Payload and verdict transactions that the block still owes us, oldest
	// first.
	mrc_out_t due_frame_outputs [$];

	// Response bytes under construction for the next frame to send.
	logic [7:0] frame_bytes [$];

	int items_sent    = 0;
	int fault_count   = 0;
	int payload_total = 0;
	int verdict_tally [5] = '{default: 0};
	int quiet_cycles  = 0;

	modbus_rtu_response_checker #(
		.MAX_FRAME(MAX_FRAME)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_item(frame_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Frame predictor
	// ------------------------------------------------------------------------

	// One byte step of the reflected CRC-16 used on Modbus RTU lines.
	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Frame capture restarts on every arm and after every end of frame; the
	// armed expectations are left alone.
	function automatic void clear_capture();
		rx_len    = 0;
		crc_acc   = CRC_INIT;
		recent[0] = 8'h00;
		recent[1] = 8'h00;
		recent[2] = 8'h00;
		hdr_slave = 8'h00;
		hdr_fn    = 8'h00;
		hdr_count = 8'h00;
	endfunction

	// The verdict checks are applied in order of precedence: length first,
	// then the CRC, then the header and the sizes that depend on the function.
	function automatic logic [2:0] frame_verdict();
		bit hdr_ok;
		hdr_ok = (hdr_slave == armed_slave) && (hdr_fn == armed_fn);
		if (rx_len < MIN_FRAME)
			return ST_TOO_SHORT;
		// The CRC travels low byte first, so the newest byte is its high half.
		if ({recent[0], recent[1]} != crc_acc)
			return ST_CRC_ERROR;
		case (armed_fn)
			FN_READ_COILS, FN_READ_DISCRETE: begin
				if (!hdr_ok)
					return ST_BAD_RESP;
				if (int'(hdr_count) + 5 != rx_len)
					return ST_BAD_SIZE;
			end
			FN_READ_HOLDING, FN_READ_INPUT_REG: begin
				if (!hdr_ok)
					return ST_BAD_RESP;
				if (int'(hdr_count) + 5 != rx_len || int'(hdr_count) != 2 * int'(armed_qty))
					return ST_BAD_SIZE;
			end
			FN_WRITE_SINGLE, FN_WRITE_MULTIPLE: begin
				if (rx_len < MIN_ECHO || !hdr_ok)
					return ST_BAD_RESP;
			end
			default: begin
				if (!hdr_ok)
					return ST_BAD_RESP;
			end
		endcase
		return ST_OK;
	endfunction

	// Advances the predictor by one input transaction and reports whether it
	// yields a result. A byte is only released once two newer bytes have
	// arrived, since the last two bytes of any frame are its CRC.
	function automatic bit frame_check_step(input mrc_in_t it, output mrc_out_t res);
		int off;
		bit made;
		res  = '0;
		made = 1'b0;
		case (it.kind)
			KIND_ARM: begin
				armed_slave = it.expect_slave;
				armed_fn    = it.expect_function;
				armed_qty   = it.expect_quantity;
				clear_capture();
			end
			KIND_BYTE: begin
				if (rx_len < MAX_FRAME) begin
					if (rx_len >= 2) begin
						crc_acc = crc16_fold(crc_acc, recent[1]);
						off = rx_len - 5;
						if (off >= 0) begin
							if (armed_fn == FN_READ_COILS || armed_fn == FN_READ_DISCRETE) begin
								res.out_kind  = OUT_DATA;
								res.out_value = {8'h00, recent[1]};
								res.out_index = off[7:0];
								made = 1'b1;
							end else if ((armed_fn == FN_READ_HOLDING ||
									armed_fn == FN_READ_INPUT_REG) && off[0]) begin
								res.out_kind  = OUT_REG;
								res.out_value = {recent[2], recent[1]};
								res.out_index = off[8:1];
								made = 1'b1;
							end
						end
					end
					if (rx_len == 0)
						hdr_slave = it.rx_byte;
					else if (rx_len == 1)
						hdr_fn = it.rx_byte;
					else if (rx_len == 2)
						hdr_count = it.rx_byte;
					recent[2] = recent[1];
					recent[1] = recent[0];
					recent[0] = it.rx_byte;
					rx_len++;
				end
			end
			KIND_END: begin
				res.out_kind   = OUT_STATUS;
				res.out_value  = {8'h00, hdr_count};
				res.status     = frame_verdict();
				res.frame_done = 1'b1;
				made = 1'b1;
				clear_capture();
			end
			default: begin
			end
		endcase
		return made;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Fields that the kind does not use are filled with random bits, so that
	// every input bit toggles in the course of the run.
	function automatic mrc_in_t noise_item();
		logic [63:0] r;
		mrc_in_t it;
		r  = {$urandom, $urandom};
		it = r[$bits(mrc_in_t)-1:0];
		if (it.expect_quantity > QTY_MAX)
			it.expect_quantity = it.expect_quantity - 11'd1024;
		return it;
	endfunction

	// Appends the CRC of everything queued so far, low byte first.
	function automatic void seal_frame();
		logic [15:0] c;
		c = CRC_INIT;
		foreach (frame_bytes[i])
			c = crc16_fold(c, frame_bytes[i]);
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
	endfunction

	// Builds a sealed reply: address, function, then body_len bytes of which
	// the first is given (the byte count field on reads).
	function automatic void build_reply(input logic [7:0] slave, input logic [7:0] fn,
			input logic [7:0] lead, input int body_len);
		frame_bytes.delete();
		frame_bytes.push_back(slave);
		frame_bytes.push_back(fn);
		for (int i = 0; i < body_len; i++)
			frame_bytes.push_back(i == 0 ? lead : 8'($urandom_range(0, 255)));
		seal_frame();
	endfunction

	// Offers one transaction after a random gap and holds it until the block
	// takes it. Called at a rising edge and returns at the accepting edge, so
	// valid is only ever assigned once in any time step.
	task automatic send_item(input mrc_in_t it);
		int gap;
		mrc_out_t res;
		gap = tx_idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_valid <= 1'b1;
		frame_item  <= it;
		do
			@(posedge clk);
		while (frame_stall);
		// Unused kinds and bytes past the capture limit are not counted as
		// traffic, since the block does nothing with them.
		if (it.kind != KIND_UNUSED && !(it.kind == KIND_BYTE && rx_len >= MAX_FRAME))
			items_sent++;
		if (frame_check_step(it, res))
			due_frame_outputs.push_back(res);
	endtask

	task automatic send_arm(input logic [7:0] slave, input logic [7:0] fn,
			input logic [10:0] qty);
		mrc_in_t it;
		it = noise_item();
		it.kind            = KIND_ARM;
		it.expect_slave    = slave;
		it.expect_function = fn;
		it.expect_quantity = qty;
		send_item(it);
	endtask

	// Sends the queued frame bytes followed by the end-of-frame transaction.
	task automatic send_frame();
		mrc_in_t it;
		foreach (frame_bytes[i]) begin
			it = noise_item();
			it.kind    = KIND_BYTE;
			it.rx_byte = frame_bytes[i];
			send_item(it);
		end
		it = noise_item();
		it.kind = KIND_END;
		send_item(it);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// An end of frame straight after reset is judged against the all-zero
	// expectations and must report a frame that is too short; the unused kind
	// must produce nothing at all.
	task automatic test_idle_kinds();
		mrc_in_t it;
		it = noise_item();
		it.kind = KIND_END;
		send_item(it);
		it = noise_item();
		it.kind = KIND_UNUSED;
		send_item(it);
	endtask

	// A clean holding register read of one register, with byte extremes in
	// the register word and a top slave address.
	task automatic test_register_reply();
		send_arm(8'hFF, FN_READ_HOLDING, 11'd1);
		frame_bytes = '{8'hFF, FN_READ_HOLDING, 8'h02, 8'h00, 8'hFF};
		seal_frame();
		send_frame();
	endtask

	// Four bytes are below the shortest frame; the armed read stays in force.
	task automatic test_short_frame();
		frame_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF};
		send_frame();
	endtask

	// A single flipped bit in the trailing CRC must be caught.
	task automatic test_crc_error();
		frame_bytes = '{8'hFF, FN_READ_HOLDING, 8'h02, 8'h12, 8'h34};
		seal_frame();
		frame_bytes[frame_bytes.size() - 1] ^= 8'h80;
		send_frame();
	endtask

	// A write echo that carries a good CRC but is shorter than eight bytes is
	// a bad response; the quantity is at its top value and plays no part.
	task automatic test_write_echo();
		send_arm(8'h00, FN_WRITE_SINGLE, 11'(QTY_MAX));
		frame_bytes = '{8'h00, FN_WRITE_SINGLE, 8'hFF};
		seal_frame();
		send_frame();
	endtask

	// The largest register read that fits, then a coil read that fills the
	// capture exactly and runs two bytes past it. The trailing bytes must be
	// dropped, so the second frame is still judged good.
	task automatic test_frame_limit();
		build_reply(8'h5A, FN_READ_INPUT_REG, 8'd250, 251);
		send_arm(8'h5A, FN_READ_INPUT_REG, 11'd125);
		send_frame();
		build_reply(8'hA5, FN_READ_COILS, 8'd251, 252);
		frame_bytes.push_back(8'h00);
		frame_bytes.push_back(8'hFF);
		send_arm(8'hA5, FN_READ_COILS, 11'(QTY_MAX));
		send_frame();
	endtask

	// The result side holds off for a long stretch while the sender keeps
	// offering bytes back to back, so the block fills and stalls its input.
	task automatic test_fill_up();
		tx_idle_on   = 1'b0;
		hold_off_req = 1'b1;
		build_reply(8'h11, FN_READ_COILS, 8'd38, 39);
		send_arm(8'h11, FN_READ_COILS, 11'd300);
		send_frame();
		tx_idle_on = 1'b1;
	endtask

	// Mostly well-formed replies with random content so that the verdict
	// logic sees good frames of every kind, mixed with broken frames, replies
	// to unusual function codes and plain noise.
	task automatic test_random_traffic();
		int pick;
		int qty;
		int count;
		int k;
		logic [7:0] slave;
		logic [7:0] arm_slave;
		logic [7:0] fn;
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 7) == 0) begin
				tx_idle_on = ($urandom_range(0, 2) != 0);
				rx_idle_on = ($urandom_range(0, 2) != 0);
			end
			pick  = $urandom_range(0, 99);
			slave = 8'($urandom_range(0, 255));
			arm_slave = slave;
			if (pick < 70) begin
				case ($urandom_range(0, 3))
					0: fn = FN_READ_COILS;
					1: fn = FN_READ_DISCRETE;
					2: fn = FN_READ_HOLDING;
					default: fn = FN_READ_INPUT_REG;
				endcase
				// Most reads are short; now and then one is long.
				if (fn == FN_READ_HOLDING || fn == FN_READ_INPUT_REG) begin
					qty = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 125) :
						$urandom_range(1, 6);
					count = 2 * qty;
				end else begin
					qty = ($urandom_range(0, 24) == 0) ? $urandom_range(1, QTY_MAX) :
						$urandom_range(1, 40);
					count = (qty + 7) / 8;
				end
				build_reply(slave, fn, 8'(count), count + 1);
				if (pick >= 55) begin
					case ($urandom_range(0, 5))
						0: begin
							k = $urandom_range(0, frame_bytes.size() - 1);
							frame_bytes[k] ^= 8'(1 << $urandom_range(0, 7));
						end
						1: frame_bytes.delete($urandom_range(0, frame_bytes.size() - 1));
						2: frame_bytes.push_back(8'($urandom_range(0, 255)));
						3: arm_slave ^= 8'(1 << $urandom_range(0, 7));
						4: qty = qty - 1;
						default: begin
							k = $urandom_range(0, 4);
							while (frame_bytes.size() > k)
								void'(frame_bytes.pop_back());
						end
					endcase
				end
				send_arm(arm_slave, fn, 11'(qty));
				send_frame();
				// A second reply against the same arm checks that the
				// expectations outlive the end of the first frame.
				if (pick < 55 && $urandom_range(0, 4) == 0) begin
					build_reply(slave, fn, 8'(count), count + 1);
					send_frame();
				end
			end else if (pick < 82) begin
				fn = $urandom_range(0, 1) ? FN_WRITE_SINGLE : FN_WRITE_MULTIPLE;
				build_reply(slave, fn, 8'($urandom_range(0, 255)),
					($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 4);
				send_arm(slave, fn, 11'($urandom_range(0, QTY_MAX)));
				send_frame();
			end else if (pick < 92) begin
				fn = 8'($urandom_range(0, 255));
				build_reply(slave, fn, 8'($urandom_range(0, 255)), $urandom_range(0, 10));
				if ($urandom_range(0, 3) != 0)
					send_arm(slave, fn, 11'($urandom_range(0, QTY_MAX)));
				else
					send_arm(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						11'($urandom_range(0, QTY_MAX)));
				send_frame();
			end else begin
				repeat ($urandom_range(1, 6))
					send_item(noise_item());
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	// After each accepted result the receiver draws a stall length. A pending
	// hold-off request takes precedence and keeps stall high for a long hold-off
	// counted here, then clears the request.
	initial begin : receiver
		int pause;
		result_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
				hold_off_req = 1'b0;
			end else if (result_valid && !result_stall) begin
				pause = rx_idle_on ? $urandom_range(0, 9) : 0;
				if (pause > 0) begin
					result_stall <= 1'b1;
					repeat (pause) @(posedge clk);
					result_stall <= 1'b0;
				end
			end
		end
	end

	function automatic void report_fault(input string what, input mrc_out_t want,
			input mrc_out_t got);
		fault_count++;
		if (fault_count <= MISMATCH_SHOWN)
			$display("%0t %s: expected kind %0d value %04h index %0d status %0d done %0b,",
				$time, what, want.out_kind, want.out_value, want.out_index,
				want.status, want.frame_done,
				" got kind %0d value %04h index %0d status %0d done %0b",
				got.out_kind, got.out_value, got.out_index, got.status, got.frame_done);
	endfunction

	// Every accepted result is matched against the oldest outstanding
	// prediction, field by field.
	always @(posedge clk) begin
		mrc_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (due_frame_outputs.size() == 0) begin
				report_fault("result with nothing outstanding", '0, result_item);
			end else begin
				want = due_frame_outputs.pop_front();
				if (result_item.out_kind !== want.out_kind ||
						result_item.out_value !== want.out_value ||
						result_item.out_index !== want.out_index ||
						result_item.status !== want.status ||
						result_item.frame_done !== want.frame_done)
					report_fault("result mismatch", want, result_item);
				if (want.out_kind == OUT_STATUS)
					verdict_tally[want.status]++;
				else
					payload_total++;
			end
		end
	end

	// The watchdog only counts while something is on offer or still owed,
	// so deliberate idling at the end of the run does not trip it.
	always @(posedge clk) begin
		if ((frame_valid && !frame_stall) || (result_valid && !result_stall) ||
				!(frame_valid || due_frame_outputs.size() != 0)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence of tests
	// ------------------------------------------------------------------------

	initial begin
		frame_valid <= 1'b0;
		frame_item  <= '0;
		arst_n      <= 1'b0;
		armed_slave = 8'h00;
		armed_fn    = 8'h00;
		armed_qty   = 11'd0;
		clear_capture();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_kinds();
		test_register_reply();
		test_short_frame();
		test_crc_error();
		test_write_echo();
		test_frame_limit();
		test_fill_up();
		test_random_traffic();
		frame_valid <= 1'b0;

		// Wait for every owed transaction, then a drain period in case the
		// block produces something it should not.
		while (due_frame_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions; checked %0d payload results and %0d frame verdicts.",
			items_sent, payload_total, verdict_tally.sum());
		$display("Verdicts ok %0d, short %0d, crc %0d, bad response %0d, bad size %0d; %0d faults.",
			verdict_tally[ST_OK], verdict_tally[ST_TOO_SHORT], verdict_tally[ST_CRC_ERROR],
			verdict_tally[ST_BAD_RESP], verdict_tally[ST_BAD_SIZE], fault_count);
		if (fault_count == 0 && due_frame_outputs.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_crc16_step.sv
hw/rtl/mrc_frame_engine.sv
hw/rtl/modbus_rtu_response_checker.sv
tb/sv/modbus_rtu_response_checker_tb.sv
